[rtl/opsa_pkg.sv]
// Shared constants, codes and control types of the object pool slot allocator.
`timescale 1ns / 1ps

package opsa_pkg;

  // Fixed field widths of the request and response transactions
  localparam int SLOT_W   = 6;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // Default number of slots in the pool
  localparam int POOL_SIZE_DEF = 64;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRY     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;

  // Response status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RELEASE = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the request and start the table reads
    logic commit;   // apply the update and load the response register
  } cmd_t;

endpackage

[rtl/opsa_if.sv]
// Request and response channel interfaces of the object pool slot allocator.
`timescale 1ns / 1ps

interface opsa_req_if;
  logic                         valid;
  logic                         ready;
  logic [opsa_pkg::KIND_W-1:0]  kind;
  logic [opsa_pkg::SLOT_W-1:0]  slot;

  modport source (output valid, output kind, output slot, input ready);
  modport sink   (input valid, input kind, input slot, output ready);
endinterface

interface opsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [opsa_pkg::SLOT_W-1:0]   granted_slot;
  logic                          granted;
  logic [opsa_pkg::STATUS_W-1:0] status;

  modport source (output valid, output granted_slot, output granted, output status,
                  input ready);
  modport sink   (input valid, input granted_slot, input granted, input status,
                  output ready);
endinterface

[rtl/opsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module opsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/opsa_ctrl.sv]
// Controller of the slot allocator: request sequencing and response valid.
`timescale 1ns / 1ps

module opsa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output opsa_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  // Derive the commands and the next state
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the response valid until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

[rtl/opsa_dp.sv]
// Datapath of the slot allocator: in-use map, release queue, counters, response.
`timescale 1ns / 1ps

module opsa_dp #(
  parameter int POOL_SIZE = opsa_pkg::POOL_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  opsa_pkg::cmd_t                  cmd,
  input  logic [opsa_pkg::KIND_W-1:0]     kind,
  input  logic [opsa_pkg::SLOT_W-1:0]     slot,
  output logic [opsa_pkg::SLOT_W-1:0]     granted_slot,
  output logic                            granted,
  output logic [opsa_pkg::STATUS_W-1:0]   status
);

  localparam int MW = $clog2(POOL_SIZE);
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam int XW = (CW > opsa_pkg::SLOT_W) ? CW : opsa_pkg::SLOT_W;
  localparam logic [MW-1:0] LAST = MW'(POOL_SIZE - 1);
  localparam logic [CW-1:0] FULL = CW'(POOL_SIZE);

  // Queue ends, counters and the latched request
  logic [MW-1:0]                   head;
  logic [MW-1:0]                   tail;
  logic [CW-1:0]                   count;
  logic [CW-1:0]                   created;
  logic [opsa_pkg::KIND_W-1:0]     kind_q;
  logic [opsa_pkg::SLOT_W-1:0]     slot_q;

  logic [opsa_pkg::SLOT_W-1:0]     q_rd;
  logic                            map_rd;
  logic [XW-1:0]                   slot_in_x;
  logic [XW-1:0]                   slot_q_x;
  logic [XW-1:0]                   q_rd_x;
  logic [XW-1:0]                   created_x;

  logic                            is_alloc;
  logic                            has_q;
  logic                            do_pop;
  logic                            do_fresh;
  logic                            rel_ok;
  logic                            map_we;
  logic [MW-1:0]                   map_waddr;
  logic                            q_we;

  logic [opsa_pkg::SLOT_W-1:0]     gslot_next;
  logic                            granted_next;
  logic [opsa_pkg::STATUS_W-1:0]   status_next;

  assign slot_in_x = XW'(slot);
  assign slot_q_x  = XW'(slot_q);
  assign q_rd_x    = XW'(q_rd);
  assign created_x = XW'(created);

  // Release queue storage
  opsa_ram #(
    .WIDTH (opsa_pkg::SLOT_W),
    .DEPTH (POOL_SIZE)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail),
    .wdata (slot_q),
    .re    (cmd.capture),
    .raddr (head),
    .rdata (q_rd)
  );

  // In-use map; entries at or above the created count read as free
  opsa_ram #(
    .WIDTH (1),
    .DEPTH (POOL_SIZE)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (!rel_ok),
    .re    (cmd.capture),
    .raddr (slot_in_x[MW-1:0]),
    .rdata (map_rd)
  );

  // Decide the operation
  always_comb begin
    is_alloc = (kind_q == opsa_pkg::KIND_ALLOC) || (kind_q == opsa_pkg::KIND_TRY);
    has_q    = (count != '0);
    do_pop   = is_alloc && has_q;
    do_fresh = (kind_q == opsa_pkg::KIND_ALLOC) && !has_q && (created != FULL);
    rel_ok   = (kind_q == opsa_pkg::KIND_RELEASE) && (slot_q_x < created_x) && map_rd
               && (count != FULL);
  end

  // Select the map and queue writes
  always_comb begin
    map_we = cmd.commit && (do_pop || do_fresh || rel_ok);
    q_we   = cmd.commit && rel_ok;
    priority if (do_pop) begin
      map_waddr = q_rd_x[MW-1:0];
    end else if (do_fresh) begin
      map_waddr = created_x[MW-1:0];
    end else begin
      map_waddr = slot_q_x[MW-1:0];
    end
  end

  // Form the response
  always_comb begin
    granted_next = do_pop || do_fresh;
    priority if (do_pop) begin
      gslot_next = q_rd;
    end else if (do_fresh) begin
      gslot_next = created_x[opsa_pkg::SLOT_W-1:0];
    end else begin
      gslot_next = '0;
    end
    priority if (is_alloc && !granted_next) begin
      status_next = opsa_pkg::STATUS_EMPTY;
    end else if ((kind_q == opsa_pkg::KIND_RELEASE) && !rel_ok) begin
      status_next = opsa_pkg::STATUS_BAD_RELEASE;
    end else begin
      status_next = opsa_pkg::STATUS_OK;
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      slot_q <= slot;
    end
  end

  // Load the response register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      granted_slot <= gslot_next;
      granted      <= granted_next;
      status       <= status_next;
    end
  end

  // Advance the queue ends and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      created <= '0;
    end else if (cmd.commit) begin
      if (do_pop) begin
        head  <= (head == LAST) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
      if (rel_ok) begin
        tail  <= (tail == LAST) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end
      if (do_fresh) begin
        created <= created + 1'b1;
      end
    end
  end

endmodule

[rtl/object_pool_slot_allocator.sv]
// Object pool slot allocator: FIFO reuse of released slots, then fresh slots.
//
// Usage: requests arrive on the req channel (kind, slot); each request yields
// exactly one response transaction on the rsp channel (granted_slot, granted,
// status). Allocate reuses the oldest released slot, else the next unused one;
// try-allocate reuses released slots only; release returns an allocated slot.
// One request is in flight at a time, so the block takes no new request
// before it has committed the last one: first come the registered reads of
// the in-use map and the release-queue head, then the update of both
// memories and the load of the response register.
// The response register decouples the channels: a new request is taken while
// the previous response still waits. If the receiver stalls, the request in
// flight holds until the response register frees, and req.ready stays low.
// Reset (rst, synchronous) empties the queue and makes every slot free at
// once; no clearing pass is needed, as slots never handed out read as free.
`timescale 1ns / 1ps

module object_pool_slot_allocator #(
  parameter int POOL_SIZE = opsa_pkg::POOL_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  opsa_req_if.sink   req,
  opsa_rsp_if.source rsp
);

  opsa_pkg::cmd_t cmd;

  // Sequence requests
  opsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Hold the pool state and form responses
  opsa_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (req.kind),
    .slot         (req.slot),
    .granted_slot (rsp.granted_slot),
    .granted      (rsp.granted),
    .status       (rsp.status)
  );

`ifndef SYNTHESIS
  // One request in flight: a taken request closes the request channel
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in flight");

  // Every commit presents a response in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("commit without a response");

  // A response only appears after a commit
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.commit))
    else $error("response valid without a commit");

  // A commit never overwrites a response that has not been taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp.valid || rsp.ready))
    else $error("response overwritten before transfer");
`endif

endmodule
